>>> src/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared constants, types and tables for the haversine distance core.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 30;
    localparam int SQRT_W       = 2 * SQRT_STEPS - 1;
    localparam int SQRT_STEP_W  = $clog2(SQRT_STEPS);
    localparam int CW           = 34;
    localparam int STEP_W       = 6;
    localparam int LATENCY      = 12 + 2 * CORDIC_STEPS + SQRT_STEPS;

    localparam logic signed [31:0] FULL_TURN    = 32'sd432000000;
    localparam logic signed [31:0] HALF_TURN    = 32'sd216000000;
    localparam logic signed [31:0] QUARTER_TURN = 32'sd108000000;

    localparam logic signed [27:0] RAD_K24      = 28'sd131004292;
    localparam logic signed [CW-1:0] CORDIC_START = CW'(326016437);
    localparam logic [28:0] DEG_RECIP           = 29'd281474976;
    localparam logic [27:0] DEG_SCALE           = 28'd1000000;
    localparam logic [27:0] MIN_FOLD            = 28'd400000;
    localparam logic [14:0] DIST_SCALE          = 15'd20000;
    localparam logic [23:0] RADIUS_RESET        = 24'd6371;
    localparam logic [38:0] DIST_MAX            = 39'h7F_FFFF_FFFF;
    localparam logic [29:0] ONE_Q               = 30'h2000_0000;

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    function automatic logic signed [CW-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            6'd0:    v = CW'(421657428);
            6'd1:    v = CW'(248918915);
            6'd2:    v = CW'(131521918);
            6'd3:    v = CW'(66762579);
            6'd4:    v = CW'(33510843);
            6'd5:    v = CW'(16771758);
            6'd6:    v = CW'(8387925);
            6'd7:    v = CW'(4194219);
            6'd8:    v = CW'(2097141);
            6'd9:    v = CW'(1048575);
            default: v = (i < 6'd30) ? (CW'(1) <<< (6'd29 - i)) : '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/hpd_pos_if.sv
// ----------------------------------------------------------------------------
// hpd_pos_if
// Valid/ready channel carrying a pair of NMEA positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpd_pos_if;
    logic        valid;
    logic        ready;
    logic [26:0] cur_lat_mag;
    logic        cur_lat_south;
    logic [27:0] cur_lon_mag;
    logic        cur_lon_west;
    logic [26:0] ref_lat_mag;
    logic        ref_lat_south;
    logic [27:0] ref_lon_mag;
    logic        ref_lon_west;

    modport source (
        output valid, cur_lat_mag, cur_lat_south, cur_lon_mag, cur_lon_west,
               ref_lat_mag, ref_lat_south, ref_lon_mag, ref_lon_west,
        input  ready
    );
    modport sink (
        input  valid, cur_lat_mag, cur_lat_south, cur_lon_mag, cur_lon_west,
               ref_lat_mag, ref_lat_south, ref_lon_mag, ref_lon_west,
        output ready
    );
endinterface

`default_nettype wire

>>> src/hpd_dist_if.sv
// ----------------------------------------------------------------------------
// hpd_dist_if
// Valid/ready channel carrying one distance word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpd_dist_if;
    logic        valid;
    logic        ready;
    logic [38:0] distance;

    modport source (output valid, distance, input ready);
    modport sink (input valid, distance, output ready);
endinterface

`default_nettype wire

>>> src/hpd_cordic_cell.sv
// ----------------------------------------------------------------------------
// hpd_cordic_cell
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_cordic_cell (
    input  wire logic                            clk,
    input  wire logic                            en,
    input  wire hpd_pkg::cordic_mode_t           mode,
    input  wire logic [hpd_pkg::STEP_W-1:0]      step,
    input  wire logic signed [hpd_pkg::CW-1:0]   x_in,
    input  wire logic signed [hpd_pkg::CW-1:0]   y_in,
    input  wire logic signed [hpd_pkg::CW-1:0]   z_in,
    output logic signed [hpd_pkg::CW-1:0]        x_out,
    output logic signed [hpd_pkg::CW-1:0]        y_out,
    output logic signed [hpd_pkg::CW-1:0]        z_out
);

    logic signed [hpd_pkg::CW-1:0] x_reg, y_reg, z_reg;
    logic signed [hpd_pkg::CW-1:0] x_next, y_next, z_next;
    logic signed [hpd_pkg::CW-1:0] dx, dy, ang;
    logic                          dir;

    always_comb
    begin
        dx  = y_in >>> step;
        dy  = x_in >>> step;
        ang = hpd_pkg::atan_entry(step);
        // rotate drives z to zero, vectoring drives y to zero
        dir = (mode == hpd_pkg::CORDIC_ROTATE) ? !z_in[hpd_pkg::CW-1] : y_in[hpd_pkg::CW-1];
        if (dir)
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ang;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

`default_nettype wire

>>> src/hpd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// hpd_sqrt_cell
// One registered step of a restoring square root, two radicand bits a step.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_sqrt_cell (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [hpd_pkg::SQRT_STEP_W-1:0]     step,
    input  wire logic [hpd_pkg::SQRT_W-1:0]          n_in,
    input  wire logic [hpd_pkg::SQRT_W-1:0]          res_in,
    output logic [hpd_pkg::SQRT_W-1:0]               n_out,
    output logic [hpd_pkg::SQRT_W-1:0]               res_out
);

    logic [hpd_pkg::SQRT_W-1:0] n_reg, res_reg, n_next, res_next, bit_val;
    logic [hpd_pkg::SQRT_W:0]   trial;
    logic [5:0]                 sh;

    always_comb
    begin
        sh      = 6'(hpd_pkg::SQRT_W - 1) - {step, 1'b0};
        bit_val = hpd_pkg::SQRT_W'(1) << sh;
        trial   = {1'b0, res_in} + {1'b0, bit_val};
        if ({1'b0, n_in} >= trial)
        begin
            n_next   = n_in - trial[hpd_pkg::SQRT_W-1:0];
            res_next = (res_in >> 1) + bit_val;
        end
        else
        begin
            n_next   = n_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            res_reg <= res_next;
        end
    end

    assign n_out   = n_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

>>> src/haversine_position_distance_core.sv
// ----------------------------------------------------------------------------
// haversine_position_distance_core
// Great-circle distance between two NMEA positions, fully pipelined.
// ----------------------------------------------------------------------------
// pos_in carries one word with the current fix and the reference position;
// dist_out returns one distance word per input word, in order, in 1/10000 of
// the radius unit, saturated to 39 bits. cfg_we/cfg_wdata load the sphere
// radius (6371 after reset); write it only while no word is in flight.
// The stages in order: angle conversion and folding, four rows of 30 CORDIC
// rotation cells, the product registers, two rows of 30 square root cells,
// a row of 30 CORDIC vectoring cells and the scaling registers. One word
// enters per cycle unless dist_out stalls; the pipeline holds up to 102 words.
// The whole row advances together: when dist_out holds a word that is not
// taken, the pipeline freezes and pos_in.ready drops in the same cycle.
// Reset clears the valid line and restores the radius; data registers are
// not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_position_distance_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata,
    hpd_pos_if.sink          pos_in,
    hpd_dist_if.source       dist_out
);

    localparam int N  = hpd_pkg::CORDIC_STEPS;
    localparam int Q  = hpd_pkg::SQRT_STEPS;
    localparam int CW = hpd_pkg::CW;
    localparam int SW = hpd_pkg::SQRT_W;

    logic                 adv;
    logic [23:0]          radius_reg;
    logic                 vld_reg [hpd_pkg::LATENCY];

    // conversion stages; up to units3, index 0 cur lat, 1 cur lon, 2 ref lat, 3 ref lon
    logic [27:0]          mag_in [4];
    logic                 neg_in [4];
    logic [56:0]          qprod [4];
    logic [27:0]          mag1_reg [4];
    logic                 neg1_reg [4];
    logic [8:0]           q1_reg [4];
    logic [27:0]          mag2_reg [4];
    logic                 neg2_reg [4];
    logic [8:0]           q2_reg [4];
    logic [27:0]          rem2 [4];
    logic [27:0]          pos3 [4];
    logic signed [31:0]   units3_reg [4];
    logic signed [31:0]   u4_reg [4];
    logic signed [31:0]   wrap5 [4];
    logic signed [31:0]   fold5 [4];
    logic                 flip5 [4];
    logic signed [27:0]   r5_reg [4];
    logic [1:0]           flip5_reg;
    logic signed [55:0]   rprod [4];
    logic signed [CW-1:0] z6_reg [4];
    logic [1:0]           flip_line_reg [N+1];

    logic signed [CW-1:0] rot_x [4][N+1];
    logic signed [CW-1:0] rot_y [4][N+1];
    logic signed [CW-1:0] rot_z [4][N+1];

    // product stages
    logic signed [30:0]   sin_a, sin_b, cos_a, cos_b;
    logic signed [31:0]   cf_a, cf_b;
    logic signed [61:0]   sq_a, sq_b;
    logic signed [63:0]   pc;
    logic signed [31:0]   h1_reg, h2_reg, p_reg, h1d_reg, hp_reg;
    logic signed [63:0]   hprod;
    logic signed [32:0]   asum;
    logic [29:0]          a_reg;

    logic [SW-1:0]        sq_n [2][Q+1];
    logic [SW-1:0]        sq_r [2][Q+1];

    logic signed [CW-1:0] vec_x [N+1];
    logic signed [CW-1:0] vec_y [N+1];
    logic signed [CW-1:0] vec_z [N+1];

    logic [30:0]          zc;
    logic [45:0]          t_reg;
    logic [49:0]          ph_reg;
    logic [43:0]          pl_reg;
    logic [44:0]          rest;
    logic [40:0]          dsum;
    logic [38:0]          dist_reg;

    assign adv          = !dist_out.valid || dist_out.ready;
    assign pos_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= hpd_pkg::RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpd_pkg::LATENCY; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= pos_in.valid;
            for (int i = 1; i < hpd_pkg::LATENCY; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // degree/minute split: estimate of mag / 1e6 by reciprocal, low by at most one
    always_comb
    begin
        mag_in[0] = {1'b0, pos_in.cur_lat_mag};
        mag_in[1] = pos_in.cur_lon_mag;
        mag_in[2] = {1'b0, pos_in.ref_lat_mag};
        mag_in[3] = pos_in.ref_lon_mag;
        neg_in[0] = pos_in.cur_lat_south;
        neg_in[1] = pos_in.cur_lon_west;
        neg_in[2] = pos_in.ref_lat_south;
        neg_in[3] = pos_in.ref_lon_west;
        for (int i = 0; i < 4; i++)
        begin
            qprod[i] = 57'(mag_in[i]) * 57'(hpd_pkg::DEG_RECIP);
            rem2[i]  = mag1_reg[i] - 28'(q1_reg[i] * 28'(hpd_pkg::DEG_SCALE));
            pos3[i]  = mag2_reg[i] - 28'(q2_reg[i] * 28'(hpd_pkg::MIN_FOLD));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag1_reg[i]   <= mag_in[i];
                neg1_reg[i]   <= neg_in[i];
                q1_reg[i]     <= qprod[i][56:48];
                mag2_reg[i]   <= mag1_reg[i];
                neg2_reg[i]   <= neg1_reg[i];
                q2_reg[i]     <= (rem2[i] >= hpd_pkg::DEG_SCALE) ? q1_reg[i] + 9'd1 : q1_reg[i];
                // dd*600000 + m equals mag - dd*400000
                units3_reg[i] <= neg2_reg[i] ? -32'(pos3[i]) : 32'(pos3[i]);
            end
            u4_reg[0] <= units3_reg[2] - units3_reg[0];
            u4_reg[1] <= units3_reg[3] - units3_reg[1];
            u4_reg[2] <= units3_reg[0] <<< 1;
            u4_reg[3] <= units3_reg[2] <<< 1;
        end
    end

    // fold into [-90, 90] degrees; cosine sign flips when folded
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            wrap5[i] = u4_reg[i][31] ? u4_reg[i] + hpd_pkg::FULL_TURN : u4_reg[i];
            if (wrap5[i] >= hpd_pkg::HALF_TURN)
            begin
                wrap5[i] = wrap5[i] - hpd_pkg::FULL_TURN;
            end
            if (wrap5[i] > hpd_pkg::QUARTER_TURN)
            begin
                fold5[i] = hpd_pkg::HALF_TURN - wrap5[i];
                flip5[i] = 1'b1;
            end
            else if (wrap5[i] < -hpd_pkg::QUARTER_TURN)
            begin
                fold5[i] = -hpd_pkg::HALF_TURN - wrap5[i];
                flip5[i] = 1'b1;
            end
            else
            begin
                fold5[i] = wrap5[i];
                flip5[i] = 1'b0;
            end
            rprod[i] = r5_reg[i] * hpd_pkg::RAD_K24;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                r5_reg[i] <= fold5[i][27:0];
                z6_reg[i] <= CW'((rprod[i] + 56'sd8388608) >>> 24);
            end
            flip5_reg        <= {flip5[3], flip5[2]};
            flip_line_reg[0] <= flip5_reg;
            for (int k = 1; k <= N; k++)
            begin
                flip_line_reg[k] <= flip_line_reg[k-1];
            end
        end
    end

    // four rows of rotation cells: two half-difference sines, two latitude cosines
    for (genvar c = 0; c < 4; c++)
    begin : g_rot
        assign rot_x[c][0] = hpd_pkg::CORDIC_START;
        assign rot_y[c][0] = '0;
        assign rot_z[c][0] = z6_reg[c];
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            hpd_cordic_cell u_cell (
                .clk   (clk),
                .en    (adv),
                .mode  (hpd_pkg::CORDIC_ROTATE),
                .step  (hpd_pkg::STEP_W'(k)),
                .x_in  (rot_x[c][k]),
                .y_in  (rot_y[c][k]),
                .z_in  (rot_z[c][k]),
                .x_out (rot_x[c][k+1]),
                .y_out (rot_y[c][k+1]),
                .z_out (rot_z[c][k+1])
            );
        end
    end

    always_comb
    begin
        sin_a = rot_y[0][N][30:0];
        sin_b = rot_y[1][N][30:0];
        cos_a = rot_x[2][N][30:0];
        cos_b = rot_x[3][N][30:0];
        cf_a  = flip_line_reg[N][0] ? -32'(cos_a) : 32'(cos_a);
        cf_b  = flip_line_reg[N][1] ? -32'(cos_b) : 32'(cos_b);
        sq_a  = sin_a * sin_a;
        sq_b  = sin_b * sin_b;
        pc    = cf_a * cf_b;
        hprod = h2_reg * p_reg;
        asum  = 33'(h1d_reg) + 33'(hp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_reg  <= 32'((sq_a + 62'sd268435456) >>> 29);
            h2_reg  <= 32'((sq_b + 62'sd268435456) >>> 29);
            p_reg   <= 32'((pc + 64'sd268435456) >>> 29);
            h1d_reg <= h1_reg;
            hp_reg  <= 32'((hprod + 64'sd268435456) >>> 29);
            if (asum[32])
            begin
                a_reg <= '0;
            end
            else if (asum > 33'sd536870912)
            begin
                a_reg <= hpd_pkg::ONE_Q;
            end
            else
            begin
                a_reg <= asum[29:0];
            end
        end
    end

    // row 0 takes sqrt(a), row 1 takes sqrt(1 - a)
    assign sq_n[0][0] = {a_reg, 29'd0};
    assign sq_n[1][0] = {hpd_pkg::ONE_Q - a_reg, 29'd0};
    assign sq_r[0][0] = '0;
    assign sq_r[1][0] = '0;

    for (genvar s = 0; s < 2; s++)
    begin : g_sqrt
        for (genvar k = 0; k < Q; k++)
        begin : g_cell
            hpd_sqrt_cell u_cell (
                .clk     (clk),
                .en      (adv),
                .step    (hpd_pkg::SQRT_STEP_W'(k)),
                .n_in    (sq_n[s][k]),
                .res_in  (sq_r[s][k]),
                .n_out   (sq_n[s][k+1]),
                .res_out (sq_r[s][k+1])
            );
        end
    end

    assign vec_x[0] = CW'(sq_r[1][Q][29:0]);
    assign vec_y[0] = CW'(sq_r[0][Q][29:0]);
    assign vec_z[0] = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_vec
        hpd_cordic_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .mode  (hpd_pkg::CORDIC_VECTOR),
            .step  (hpd_pkg::STEP_W'(k)),
            .x_in  (vec_x[k]),
            .y_in  (vec_y[k]),
            .z_in  (vec_z[k]),
            .x_out (vec_x[k+1]),
            .y_out (vec_y[k+1]),
            .z_out (vec_z[k+1])
        );
    end

    // R * angle * 20000, rounded at 2^29, split so each product stays narrow
    always_comb
    begin
        zc   = vec_z[N][CW-1] ? '0 : vec_z[N][30:0];
        rest = (45'(ph_reg[8:0]) << 20) + 45'(pl_reg) + 45'd268435456;
        dsum = 41'(ph_reg >> 9) + 41'(rest >> 29);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= 46'(zc) * 46'(hpd_pkg::DIST_SCALE);
            ph_reg   <= 50'(radius_reg) * 50'(t_reg[45:20]);
            pl_reg   <= 44'(radius_reg) * 44'(t_reg[19:0]);
            dist_reg <= (dsum > 41'(hpd_pkg::DIST_MAX)) ? hpd_pkg::DIST_MAX : dsum[38:0];
        end
    end

    assign dist_out.valid    = vld_reg[hpd_pkg::LATENCY-1];
    assign dist_out.distance = dist_reg;

endmodule

`default_nettype wire

>>> src/hpd_checker.sv
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level checks for the haversine distance core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [38:0] distance
);

    // a stalled word stays on the port
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("distance word dropped while stalled");

    // the whole pipeline freezes only on a stalled output
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("distance word present after reset");

    // a frozen pipeline cannot advance a word to the output
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid && $stable(distance))
        else $error("output changed while pipeline frozen");

    logic unused_in_valid;
    assign unused_in_valid = in_valid;

endmodule

bind haversine_position_distance_core hpd_checker u_hpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pos_in.valid),
    .in_ready  (pos_in.ready),
    .out_valid (dist_out.valid),
    .out_ready (dist_out.ready),
    .distance  (dist_out.distance)
);

`default_nettype wire
